// ===== rtl/core/adaptive_huffman_codec_macros.svh =====
// Assertion macros shared by the adaptive Huffman codec RTL.
`ifndef ADAPTIVE_HUFFMAN_CODEC_MACROS_SVH
`define ADAPTIVE_HUFFMAN_CODEC_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define AHC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define AHC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ahc_pkg.sv =====
// Types and constants of the adaptive Huffman codec.
package ahc_pkg;

	localparam int NODE_W       = 10;
	localparam int SYM_W        = 9;
	localparam int BITS_IN_BYTE = 8;
	localparam int CHUNK_BITS   = 32;
	localparam int LEN_W        = 6;
	localparam int MAX_RESULTS  = 9;

	localparam logic [NODE_W-1:0] NO_NODE = 10'h3FF;
	localparam logic [SYM_W-1:0]  ESC_SYM = 9'd256;

	typedef enum logic [4:0] {
		ST_INIT, ST_IDLE, ST_BUILD,
		ST_E_LOOK, ST_E_S2N, ST_E_WP, ST_E_WPD, ST_E_WR,
		ST_D_RD, ST_D_N, ST_D_C,
		ST_U_LOOK, ST_U_S2N, ST_U_NEW0, ST_U_NEW1, ST_U_NEW2,
		ST_RP_TOP, ST_RP_BUMP, ST_RP_SCAN,
		ST_SW_RA, ST_SW_RB, ST_SW_WA, ST_SW_WB, ST_SW_PF,
		ST_RP_PAR, ST_RP_PARD, ST_ROOT_BUMP,
		ST_EM_INIT, ST_EM_CH, ST_EM_SH, ST_OUT
	} ahc_state_t;

	// per-field write enables of the node table
	typedef struct packed {
		logic par;
		logic lft;
		logic rgt;
		logic sym;
		logic wgt;
	} ahc_wen_t;

endpackage

// ===== rtl/core/ahc_node_mem.sv =====
// Node table of the codec: parent, children, symbol and weight memories.
module ahc_node_mem #(
	parameter int MAX_NODES    = 513,
	parameter int WEIGHT_WIDTH = 32,
	localparam int NI_W        = $clog2(MAX_NODES)
) (
	input  logic                        clk,
	input  logic [NI_W-1:0]             rd_addr,
	output logic [ahc_pkg::NODE_W-1:0]  par_rd,
	output logic [ahc_pkg::NODE_W-1:0]  lft_rd,
	output logic [ahc_pkg::NODE_W-1:0]  rgt_rd,
	output logic [ahc_pkg::SYM_W-1:0]   sym_rd,
	output logic [WEIGHT_WIDTH-1:0]     wgt_rd,
	input  logic [NI_W-1:0]             wr_addr,
	input  ahc_pkg::ahc_wen_t           wen,
	input  logic [ahc_pkg::NODE_W-1:0]  par_wd,
	input  logic [ahc_pkg::NODE_W-1:0]  lft_wd,
	input  logic [ahc_pkg::NODE_W-1:0]  rgt_wd,
	input  logic [ahc_pkg::SYM_W-1:0]   sym_wd,
	input  logic [WEIGHT_WIDTH-1:0]     wgt_wd
);
	import ahc_pkg::*;

	logic [NODE_W-1:0]       par_mem [MAX_NODES];
	logic [NODE_W-1:0]       lft_mem [MAX_NODES];
	logic [NODE_W-1:0]       rgt_mem [MAX_NODES];
	logic [SYM_W-1:0]        sym_mem [MAX_NODES];
	logic [WEIGHT_WIDTH-1:0] wgt_mem [MAX_NODES];

	always_ff @(posedge clk) begin
		if (wen.par) par_mem[wr_addr] <= par_wd;
		if (wen.lft) lft_mem[wr_addr] <= lft_wd;
		if (wen.rgt) rgt_mem[wr_addr] <= rgt_wd;
		if (wen.sym) sym_mem[wr_addr] <= sym_wd;
		if (wen.wgt) wgt_mem[wr_addr] <= wgt_wd;
	end

	always_ff @(posedge clk) begin
		par_rd <= par_mem[rd_addr];
		lft_rd <= lft_mem[rd_addr];
		rgt_rd <= rgt_mem[rd_addr];
		sym_rd <= sym_mem[rd_addr];
		wgt_rd <= wgt_mem[rd_addr];
	end

endmodule

// ===== rtl/core/adaptive_huffman_codec.sv =====
// Top level of the adaptive (FGK) Huffman byte codec.
//
// Usage: the s channel takes one request per item: a byte to encode (mode 0) or one code
// bit to decode (mode 1); tuser set rebuilds the tree holding only the escape leaf first.
// The m channel returns the results of that request: in encode mode one to nine chunks
// of up to 32 code bits (tlast on the final one), in decode mode exactly one result that
// flags a completed byte. cfg writes the mode and is always ready; write it only while idle.
// Flow: one request at a time; s_tready drops from acceptance until the last result
// is taken. An encode first walks leaf to root, then runs the update: per level a
// bump of the node weight, a scan of the nodes for the block leader and, where
// needed, a swap; then it shifts out each chunk. A decode reads one or two nodes,
// plus the update when a byte completes. The scan over the weight memory reads
// one node per cycle through the single compare unit.
// Reset: control state clears at once; node 0 is then written in the ST_INIT state,
// and the block is ready once the sequencer reaches ST_IDLE.
// Stall: a result waits in the output register while m_tready is low; the sequencer
// holds and takes no new request until it has been delivered.
`include "adaptive_huffman_codec_macros.svh"

module adaptive_huffman_codec #(
	parameter int SYMBOL_COUNT = 256,
	parameter int RAW_BITS     = 8,
	parameter int WEIGHT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] data_byte, [8] code_bit, rest zero
	input  logic        s_tuser,   // [0] start_of_block
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] code_chunk, [37:32] chunk_length, [45:38] symbol
	output logic        m_tlast,   // last_chunk
	output logic [1:0]  m_tuser,   // [0] symbol_valid, [1] weight_saturated
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data   // codec_mode
);
	import ahc_pkg::*;

	localparam int MAX_NODES = 2 * SYMBOL_COUNT + 1;
	localparam int NI_W      = $clog2(MAX_NODES);
	localparam int SYM_IW    = $clog2(SYMBOL_COUNT);
	localparam logic [NODE_W-1:0] MAXN = NODE_W'(MAX_NODES);
	localparam logic [NODE_W-1:0] CHUNK_N = NODE_W'(CHUNK_BITS);
	localparam logic [BITS_IN_BYTE-1:0] RAW_MASK = BITS_IN_BYTE'((1 << RAW_BITS) - 1);
	localparam logic [WEIGHT_WIDTH-1:0] W_ONE = WEIGHT_WIDTH'(1);

	// clamp a link: anything outside the live table reads as the root
	function automatic logic [NODE_W-1:0] clampn(input logic [NODE_W-1:0] x,
		input logic [NODE_W-1:0] cnt);
		return (x < cnt && x < MAXN) ? x : '0;
	endfunction

	ahc_state_t st_q, nxt;

	// tree control state
	logic                    mode_q;
	logic [NODE_W-1:0]       cnt_q;
	logic [NODE_W-1:0]       cur_q;
	logic [3:0]              rawn_q;
	logic [BITS_IN_BYTE-1:0] rawsh_q;
	logic [SYMBOL_COUNT-1:0] vld_q;
	logic                    sat_q;

	// per-item work registers
	logic                    in_bit_q;
	logic [BITS_IN_BYTE-1:0] sym_q;
	logic                    esc_q;
	logic [NODE_W-1:0]       m_q, p_q, d_q, g_q, start_q, scan_q, rep_q, x_q, e_q;
	logic [WEIGHT_WIDTH-1:0] wn_q;
	logic [NODE_W-1:0]       ra_l_q, ra_r_q, rb_l_q, rb_r_q;
	logic [SYM_W-1:0]        ra_s_q;
	logic [WEIGHT_WIDTH-1:0] ra_w_q;
	logic [1:0]              pf_q;

	// chunk assembly and output register
	logic [NODE_W-1:0]       pb_q, rem_q;
	logic [RAW_BITS-1:0]     raw_q;
	logic [3:0]              k_q;
	logic [LEN_W-1:0]        j_q, cl_q;
	logic                    pend_s1, praw_s1, pbit_s1;
	logic [CHUNK_BITS-1:0]   chunk_q;
	logic                    last_q, dval_q;
	logic [BITS_IN_BYTE-1:0] dsym_q;

	// node table ports
	logic [NODE_W-1:0]       rd_addr, wr_addr;
	logic [NODE_W-1:0]       par_rd, lft_rd, rgt_rd;
	logic [SYM_W-1:0]        sym_rd;
	logic [WEIGHT_WIDTH-1:0] wgt_rd;
	ahc_wen_t                wen;
	logic [NODE_W-1:0]       par_wd, lft_wd, rgt_wd;
	logic [SYM_W-1:0]        sym_wd;
	logic [WEIGHT_WIDTH-1:0] wgt_wd;

	// symbol-to-leaf map and path bit buffer
	logic [NODE_W-1:0] s2n_mem [SYMBOL_COUNT];
	logic [NODE_W-1:0] s2n_rd;
	logic              s2n_we;
	logic [SYM_IW-1:0] s2n_waddr;
	logic [NODE_W-1:0] s2n_wd;
	logic              bm_mem [MAX_NODES];
	logic              bm_rd, bm_we, bm_wd;
	logic [NODE_W-1:0] bm_raddr;

	// derived values
	logic                    s_acc, m_acc;
	logic                    leaf_rd, ra_leaf, sym_in_range;
	logic [NODE_W-1:0]       t_c, rep_c, ptr_c;
	logic [WEIGHT_WIDTH-1:0] w_inc;
	logic                    w_sat;
	logic [BITS_IN_BYTE-1:0] sh_new;
	logic [3:0]              rn_new;
	logic [LEN_W-1:0]        cl_c;

	ahc_node_mem #(
		.MAX_NODES(MAX_NODES),
		.WEIGHT_WIDTH(WEIGHT_WIDTH)
	) u_nodes (
		.clk(clk),
		.rd_addr(rd_addr[NI_W-1:0]),
		.par_rd(par_rd),
		.lft_rd(lft_rd),
		.rgt_rd(rgt_rd),
		.sym_rd(sym_rd),
		.wgt_rd(wgt_rd),
		.wr_addr(wr_addr[NI_W-1:0]),
		.wen(wen),
		.par_wd(par_wd),
		.lft_wd(lft_wd),
		.rgt_wd(rgt_wd),
		.sym_wd(sym_wd),
		.wgt_wd(wgt_wd)
	);

	assign s_acc     = s_tvalid && s_tready;
	assign m_acc     = m_tvalid && m_tready;
	assign s_tready  = (st_q == ST_IDLE);
	assign m_tvalid  = (st_q == ST_OUT);
	assign cfg_ready = 1'b1;
	assign m_tdata   = {2'b00, dsym_q, cl_q, chunk_q};
	assign m_tlast   = last_q;
	assign m_tuser   = {sat_q, dval_q};

	assign leaf_rd      = (lft_rd == NO_NODE) && (rgt_rd == NO_NODE);
	assign ra_leaf      = (ra_l_q == NO_NODE) && (ra_r_q == NO_NODE);
	assign sym_in_range = (int'(sym_q) < SYMBOL_COUNT);
	// looked-up leaf of sym_q, or no node when the symbol is absent
	assign t_c   = (sym_in_range && vld_q[sym_q[SYM_IW-1:0]]) ? s2n_rd : NO_NODE;
	assign rep_c = scan_q + NODE_W'(1);
	// the single shared increment and compare unit works on wgt_rd
	assign w_sat = (wgt_rd == '1);
	assign w_inc = w_sat ? wgt_rd : wgt_rd + W_ONE;
	assign sh_new = {rawsh_q[BITS_IN_BYTE-2:0], in_bit_q};
	assign rn_new = rawn_q + 4'd1;
	assign cl_c   = (rem_q > CHUNK_N) ? LEN_W'(CHUNK_BITS) : rem_q[LEN_W-1:0];
	assign bm_raddr = pb_q - NODE_W'(1);

	always_comb begin
		case (pf_q)
			2'd0:    ptr_c = rb_l_q;
			2'd1:    ptr_c = rb_r_q;
			2'd2:    ptr_c = ra_l_q;
			default: ptr_c = ra_r_q;
		endcase
	end

	// symbol map and path buffer memories
	always_ff @(posedge clk) begin
		if (s2n_we) s2n_mem[s2n_waddr] <= s2n_wd;
		s2n_rd <= s2n_mem[sym_q[SYM_IW-1:0]];
		if (bm_we) bm_mem[d_q[NI_W-1:0]] <= bm_wd;
		bm_rd <= bm_mem[bm_raddr[NI_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_INIT;
		end else begin
			st_q <= nxt;
		end
	end

	// sequencer: next state and memory controls
	always_comb begin
		nxt       = st_q;
		rd_addr   = '0;
		wr_addr   = '0;
		wen       = '0;
		par_wd    = '0;
		lft_wd    = NO_NODE;
		rgt_wd    = NO_NODE;
		sym_wd    = ESC_SYM;
		wgt_wd    = W_ONE;
		s2n_we    = 1'b0;
		s2n_waddr = '0;
		s2n_wd    = '0;
		bm_we     = 1'b0;
		bm_wd     = (rgt_rd == m_q);
		case (st_q)
			ST_INIT: begin
				wen = '{par: 1'b1, lft: 1'b1, rgt: 1'b1, sym: 1'b1, wgt: 1'b1};
				nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_acc) begin
					if (s_tuser)     nxt = ST_BUILD;
					else if (mode_q) nxt = ST_D_RD;
					else             nxt = ST_E_LOOK;
				end
			end
			ST_BUILD: begin
				// node 0 becomes the lone escape leaf
				wen = '{par: 1'b1, lft: 1'b1, rgt: 1'b1, sym: 1'b1, wgt: 1'b1};
				nxt = mode_q ? ST_D_RD : ST_E_LOOK;
			end
			ST_E_LOOK: nxt = ST_E_S2N;
			ST_E_S2N:  nxt = ST_E_WP;
			ST_E_WP: begin
				if (m_q == '0 || d_q >= MAXN) begin
					nxt = ST_U_LOOK;
				end else begin
					rd_addr = m_q;
					nxt     = ST_E_WPD;
				end
			end
			ST_E_WPD: begin
				rd_addr = clampn(par_rd, cnt_q);
				nxt     = ST_E_WR;
			end
			ST_E_WR: begin
				bm_we = 1'b1;
				nxt   = ST_E_WP;
			end
			ST_D_RD: begin
				rd_addr = clampn(cur_q, cnt_q);
				nxt     = ST_D_N;
			end
			ST_D_N: begin
				if (leaf_rd && sym_rd >= ESC_SYM) begin
					nxt = (rn_new >= 4'(RAW_BITS)) ? ST_U_LOOK : ST_OUT;
				end else if (leaf_rd) begin
					nxt = ST_OUT;
				end else begin
					rd_addr = clampn(in_bit_q ? rgt_rd : lft_rd, cnt_q);
					nxt     = ST_D_C;
				end
			end
			ST_D_C: begin
				nxt = (leaf_rd && sym_rd < ESC_SYM) ? ST_U_LOOK : ST_OUT;
			end
			ST_U_LOOK: begin
				if (!sym_in_range) nxt = mode_q ? ST_OUT : ST_EM_INIT;
				else               nxt = ST_U_S2N;
			end
			ST_U_S2N: begin
				if (t_c < cnt_q)                     nxt = ST_RP_TOP;
				else if (cnt_q + NODE_W'(2) > MAXN)  nxt = mode_q ? ST_OUT : ST_EM_INIT;
				else                                 nxt = ST_U_NEW0;
			end
			ST_U_NEW0: begin
				// old escape leaf turns internal
				wr_addr = e_q;
				wen     = '{par: 1'b0, lft: 1'b1, rgt: 1'b1, sym: 1'b1, wgt: 1'b0};
				lft_wd  = e_q + NODE_W'(1);
				rgt_wd  = e_q + NODE_W'(2);
				nxt     = ST_U_NEW1;
			end
			ST_U_NEW1: begin
				wr_addr = e_q + NODE_W'(1);
				wen     = '{par: 1'b1, lft: 1'b1, rgt: 1'b1, sym: 1'b1, wgt: 1'b1};
				par_wd  = e_q;
				sym_wd  = SYM_W'(sym_q);
				nxt     = ST_U_NEW2;
			end
			ST_U_NEW2: begin
				wr_addr   = e_q + NODE_W'(2);
				wen       = '{par: 1'b1, lft: 1'b1, rgt: 1'b1, sym: 1'b1, wgt: 1'b1};
				par_wd    = e_q;
				s2n_we    = 1'b1;
				s2n_waddr = sym_q[SYM_IW-1:0];
				s2n_wd    = e_q + NODE_W'(1);
				nxt       = ST_RP_TOP;
			end
			ST_RP_TOP: begin
				if (start_q == '0 || g_q >= MAXN) begin
					rd_addr = '0;
					nxt     = ST_ROOT_BUMP;
				end else begin
					rd_addr = start_q;
					nxt     = ST_RP_BUMP;
				end
			end
			ST_RP_BUMP: begin
				wr_addr = start_q;
				wen.wgt = 1'b1;
				wgt_wd  = w_inc;
				rd_addr = start_q - NODE_W'(1);
				nxt     = ST_RP_SCAN;
			end
			ST_RP_SCAN: begin
				// walk down toward the root while weights stay below the new one
				if (scan_q != '0 && wgt_rd < wn_q) begin
					rd_addr = scan_q - NODE_W'(1);
				end else if (rep_c != start_q) begin
					nxt = ST_SW_RA;
				end else begin
					nxt = ST_RP_PAR;
				end
			end
			ST_SW_RA: begin
				rd_addr = rep_q;
				nxt     = ST_SW_RB;
			end
			ST_SW_RB: begin
				rd_addr = start_q;
				nxt     = ST_SW_WA;
			end
			ST_SW_WA: begin
				wr_addr = rep_q;
				wen     = '{par: 1'b0, lft: 1'b1, rgt: 1'b1, sym: 1'b1, wgt: 1'b1};
				lft_wd  = lft_rd;
				rgt_wd  = rgt_rd;
				sym_wd  = sym_rd;
				wgt_wd  = wgt_rd;
				if (leaf_rd && int'(sym_rd) < SYMBOL_COUNT) begin
					s2n_we    = 1'b1;
					s2n_waddr = sym_rd[SYM_IW-1:0];
					s2n_wd    = rep_q;
				end
				nxt = ST_SW_WB;
			end
			ST_SW_WB: begin
				wr_addr = start_q;
				wen     = '{par: 1'b0, lft: 1'b1, rgt: 1'b1, sym: 1'b1, wgt: 1'b1};
				lft_wd  = ra_l_q;
				rgt_wd  = ra_r_q;
				sym_wd  = ra_s_q;
				wgt_wd  = ra_w_q;
				if (ra_leaf && int'(ra_s_q) < SYMBOL_COUNT) begin
					s2n_we    = 1'b1;
					s2n_waddr = ra_s_q[SYM_IW-1:0];
					s2n_wd    = start_q;
				end
				nxt = ST_SW_PF;
			end
			ST_SW_PF: begin
				// re-point the children of both moved subtrees
				wr_addr = ptr_c;
				wen.par = (ptr_c < MAXN);
				par_wd  = pf_q[1] ? start_q : rep_q;
				if (pf_q == 2'd3) nxt = ST_RP_PAR;
			end
			ST_RP_PAR: begin
				rd_addr = x_q;
				nxt     = ST_RP_PARD;
			end
			ST_RP_PARD: nxt = ST_RP_TOP;
			ST_ROOT_BUMP: begin
				wr_addr = '0;
				wen.wgt = 1'b1;
				wgt_wd  = w_inc;
				nxt     = mode_q ? ST_OUT : ST_EM_INIT;
			end
			ST_EM_INIT: nxt = ST_EM_CH;
			ST_EM_CH:   nxt = ST_EM_SH;
			ST_EM_SH: begin
				if (j_q == '0 && !pend_s1) nxt = ST_OUT;
			end
			ST_OUT: begin
				if (m_acc) nxt = last_q ? ST_IDLE : ST_EM_CH;
			end
			default: nxt = ST_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			cnt_q    <= NODE_W'(1);
			cur_q    <= '0;
			rawn_q   <= '0;
			rawsh_q  <= '0;
			vld_q    <= '0;
			sat_q    <= 1'b0;
			in_bit_q <= 1'b0;
			sym_q    <= '0;
			esc_q    <= 1'b0;
			m_q      <= '0;
			p_q      <= '0;
			d_q      <= '0;
			g_q      <= '0;
			start_q  <= '0;
			scan_q   <= '0;
			rep_q    <= '0;
			x_q      <= '0;
			e_q      <= '0;
			wn_q     <= '0;
			ra_l_q   <= '0;
			ra_r_q   <= '0;
			ra_s_q   <= '0;
			ra_w_q   <= '0;
			rb_l_q   <= '0;
			rb_r_q   <= '0;
			pf_q     <= '0;
			pb_q     <= '0;
			rem_q    <= '0;
			raw_q    <= '0;
			k_q      <= '0;
			j_q      <= '0;
			cl_q     <= '0;
			pend_s1  <= 1'b0;
			praw_s1  <= 1'b0;
			pbit_s1  <= 1'b0;
			chunk_q  <= '0;
			last_q   <= 1'b0;
			dval_q   <= 1'b0;
			dsym_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) mode_q <= cfg_data;
			if (s2n_we) vld_q[s2n_waddr] <= 1'b1;
			case (st_q)
				ST_IDLE: begin
					if (s_acc) begin
						sat_q    <= 1'b0;
						in_bit_q <= s_tdata[8];
						sym_q    <= s_tdata[7:0] & RAW_MASK;
					end
				end
				ST_BUILD: begin
					cnt_q   <= NODE_W'(1);
					vld_q   <= '0;
					cur_q   <= '0;
					rawn_q  <= '0;
					rawsh_q <= '0;
				end
				ST_E_S2N: begin
					// known leaf, or the escape leaf for a new or unmapped byte
					m_q   <= (t_c < cnt_q) ? t_c : cnt_q - NODE_W'(1);
					esc_q <= !(t_c < cnt_q);
					d_q   <= '0;
				end
				ST_E_WPD: p_q <= clampn(par_rd, cnt_q);
				ST_E_WR: begin
					m_q <= p_q;
					d_q <= d_q + NODE_W'(1);
				end
				ST_D_RD: m_q <= clampn(cur_q, cnt_q);
				ST_D_N: begin
					chunk_q <= '0;
					cl_q    <= '0;
					last_q  <= 1'b1;
					dval_q  <= 1'b0;
					dsym_q  <= '0;
					if (leaf_rd && sym_rd >= ESC_SYM) begin
						if (rn_new >= 4'(RAW_BITS)) begin
							sym_q   <= sh_new & RAW_MASK;
							dval_q  <= 1'b1;
							dsym_q  <= sh_new & RAW_MASK;
							rawn_q  <= '0;
							rawsh_q <= '0;
							cur_q   <= '0;
						end else begin
							rawn_q  <= rn_new;
							rawsh_q <= sh_new;
							cur_q   <= m_q;
						end
					end else if (leaf_rd) begin
						cur_q <= '0;
					end else begin
						cur_q <= clampn(in_bit_q ? rgt_rd : lft_rd, cnt_q);
					end
				end
				ST_D_C: begin
					if (leaf_rd && sym_rd < ESC_SYM) begin
						sym_q  <= sym_rd[BITS_IN_BYTE-1:0];
						dval_q <= 1'b1;
						dsym_q <= sym_rd[BITS_IN_BYTE-1:0];
						cur_q  <= '0;
					end
				end
				ST_U_S2N: begin
					start_q <= t_c;
					g_q     <= '0;
					e_q     <= cnt_q - NODE_W'(1);
				end
				ST_U_NEW2: begin
					cnt_q   <= cnt_q + NODE_W'(2);
					start_q <= e_q;
					g_q     <= '0;
				end
				ST_RP_BUMP: begin
					wn_q   <= w_inc;
					sat_q  <= sat_q | w_sat;
					scan_q <= start_q - NODE_W'(1);
				end
				ST_RP_SCAN: begin
					if (scan_q != '0 && wgt_rd < wn_q) begin
						scan_q <= scan_q - NODE_W'(1);
					end else begin
						rep_q <= rep_c;
						x_q   <= (rep_c != start_q) ? rep_c : start_q;
					end
				end
				ST_SW_RB: begin
					ra_l_q <= lft_rd;
					ra_r_q <= rgt_rd;
					ra_s_q <= sym_rd;
					ra_w_q <= wgt_rd;
				end
				ST_SW_WA: begin
					rb_l_q <= lft_rd;
					rb_r_q <= rgt_rd;
					pf_q   <= '0;
				end
				ST_SW_PF: pf_q <= pf_q + 2'd1;
				ST_RP_PARD: begin
					start_q <= clampn(par_rd, cnt_q);
					g_q     <= g_q + NODE_W'(1);
				end
				ST_ROOT_BUMP: sat_q <= sat_q | w_sat;
				ST_EM_INIT: begin
					pb_q   <= d_q;
					raw_q  <= sym_q[RAW_BITS-1:0];
					rem_q  <= d_q + (esc_q ? NODE_W'(RAW_BITS) : '0);
					k_q    <= '0;
					dval_q <= 1'b0;
					dsym_q <= '0;
				end
				ST_EM_CH: begin
					cl_q    <= cl_c;
					j_q     <= cl_c;
					chunk_q <= '0;
					pend_s1 <= 1'b0;
				end
				ST_EM_SH: begin
					// one code bit a cycle: path bits from the buffer, then raw bits
					if (pend_s1) chunk_q <= {chunk_q[CHUNK_BITS-2:0], praw_s1 ? pbit_s1 : bm_rd};
					if (j_q != '0) begin
						pend_s1 <= 1'b1;
						j_q     <= j_q - LEN_W'(1);
						if (pb_q != '0) begin
							praw_s1 <= 1'b0;
							pb_q    <= bm_raddr;
						end else begin
							praw_s1 <= 1'b1;
							pbit_s1 <= raw_q[RAW_BITS-1];
							raw_q   <= raw_q << 1;
						end
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							rem_q  <= rem_q - NODE_W'(cl_q);
							last_q <= (rem_q == NODE_W'(cl_q)) ||
								(k_q == 4'(MAX_RESULTS - 1));
						end
					end
				end
				ST_OUT: begin
					if (m_acc && !last_q) k_q <= k_q + 4'd1;
				end
				default: ;
			endcase
		end
	end

	`AHC_ASSERT_NOW(a_one_side, s_tready, !m_tvalid, "request taken while a result is pending")
	`AHC_ASSERT_NOW(a_cnt_odd, st_q != ST_INIT, cnt_q[0], "node count lost its odd parity")
	`AHC_ASSERT_NOW(a_cnt_max, 1'b1, cnt_q <= MAXN, "node count beyond table size")
	`AHC_ASSERT_NOW(a_dec_len, m_tvalid && mode_q, cl_q == '0 && last_q, "bad decode result")
	`AHC_ASSERT_NEXT(a_ready_after_last, m_acc && m_tlast, s_tready, "not ready after last")

endmodule
